FILE: rtl/gps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_pkg - parent selector shared definitions
// Table geometry, codes, register map and the entry and config types.
// ----------------------------------------------------------------------------
package gps_pkg;

	// table geometry
	localparam int MAX_POP = 64;
	localparam int IDX_W   = 6;
	localparam int SIZE_W  = 7;
	localparam int VAL_W   = 32;

	// input word command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	// selection modes
	localparam logic MODE_ROULETTE   = 1'b0;
	localparam logic MODE_TOURNAMENT = 1'b1;

	// register map, indexed by paddr[2]
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	localparam int          ADDR_W     = 3;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_POP);
	localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

	// one population entry
	typedef struct packed {
		logic [VAL_W-1:0] fitness;
		logic [VAL_W-1:0] cumulative;
	} entry_t;

	// configuration seen by the sequencer
	typedef struct packed {
		logic              mode;
		logic [SIZE_W-1:0] size;
	} cfg_t;

	// clamp population size into the legal range
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw);
		logic [SIZE_W-1:0] n;
		n = raw;
		if (raw < SIZE_MIN) begin
			n = SIZE_MIN;
		end else if (raw > SIZE_W'(MAX_POP)) begin
			n = SIZE_W'(MAX_POP);
		end
		return n;
	endfunction

endpackage

FILE: rtl/ga_parent_selection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ga_parent_selection_top - genetic-algorithm parent selector
// Load words fill the population table; draw words pick one parent by
// roulette wheel over cumulative fitness or by binary tournament on fitness.
// ----------------------------------------------------------------------------
// Sequence: a load word is written to the table when accepted. A roulette
//   draw scans the table linearly from entry 0, one table read per cycle,
//   and stops at the first cumulative above the draw; a tournament draw reads two.
// Throughput: one draw in flight; the next word is taken only after the
//   result has moved into the output register.
// Reset: arst_n clears control and registers (roulette, size 64); the table
//   is not cleared and entries must be loaded before they are drawn.
module ga_parent_selection_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// input words
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [5:0] entry_index, [37:6] entry_fitness, [69:38] entry_cumulative,
	// [101:70] draw_a, [133:102] draw_b, [135:134] zero
	input  logic [135:0]                 s_axis_tdata,
	// [0] cmd
	input  logic                         s_axis_tuser,
	// result words
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [5:0] selected_index, [6] fell_off_end, [7] zero
	output logic [7:0]                   m_axis_tdata,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gps_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	gps_pkg::cfg_t                 cfg;
	logic                          wr_en;
	logic [gps_pkg::IDX_W-1:0]     wr_addr;
	gps_pkg::entry_t               wr_data;
	logic                          rd_en;
	logic [gps_pkg::IDX_W-1:0]     rd_addr;
	gps_pkg::entry_t               rd_data;

	// configuration registers
	gps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// population table
	gps_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// selection sequencer
	gps_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data)
	);

endmodule

FILE: rtl/gps_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_table - population entry memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module gps_table (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [gps_pkg::IDX_W-1:0]   wr_addr,
	input  gps_pkg::entry_t             wr_data,
	input  logic                        rd_en,
	input  logic [gps_pkg::IDX_W-1:0]   rd_addr,
	output gps_pkg::entry_t             rd_data
);

	gps_pkg::entry_t mem_q [gps_pkg::MAX_POP];
	gps_pkg::entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/gps_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_regs - configuration registers
// APB-style register file for selection mode and population size.
// ----------------------------------------------------------------------------
module gps_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gps_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output gps_pkg::cfg_t                cfg
);

	logic                        mode_q;
	logic [gps_pkg::SIZE_W-1:0]  size_q;
	logic                        wr_go;

	assign pready = 1'b1;
	assign wr_go  = psel & penable & pwrite & pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= gps_pkg::MODE_ROULETTE;
			size_q <= gps_pkg::SIZE_RESET;
		end else if (wr_go) begin
			case (paddr[2])
				gps_pkg::REG_MODE: mode_q <= pwdata[0];
				gps_pkg::REG_SIZE: size_q <= pwdata[gps_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (paddr[2])
			gps_pkg::REG_MODE: prdata = {31'd0, mode_q};
			gps_pkg::REG_SIZE: prdata = {{(32 - gps_pkg::SIZE_W){1'b0}}, size_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg.mode = mode_q;
	assign cfg.size = size_q;

endmodule

FILE: rtl/gps_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_seq - selection sequencer
// Takes input words, writes loads to the table, scans the table for
// roulette draws, reads two entries for tournament draws, holds the result.
// ----------------------------------------------------------------------------
module gps_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gps_pkg::cfg_t               cfg,
	// input stream
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [135:0]                s_axis_tdata,
	input  logic                        s_axis_tuser,
	// result stream
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,
	// table access
	output logic                        wr_en,
	output logic [gps_pkg::IDX_W-1:0]   wr_addr,
	output gps_pkg::entry_t             wr_data,
	output logic                        rd_en,
	output logic [gps_pkg::IDX_W-1:0]   rd_addr,
	input  gps_pkg::entry_t             rd_data
);

	localparam int IW = gps_pkg::IDX_W;
	localparam int SW = gps_pkg::SIZE_W;
	localparam int VW = gps_pkg::VAL_W;
	localparam int PW = VW + SW;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_TRD1 = 6'b000100,
		ST_TRD2 = 6'b001000,
		ST_TCMP = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t           state_q;
	logic             mode_q;
	logic [SW-1:0]    n_q;
	logic [VW-1:0]    draw_q;
	logic [IW-1:0]    i1_q;
	logic [IW-1:0]    i2_q;
	logic [IW-1:0]    scan_addr_q;
	logic             issue_done_q;
	logic             chk_vld_s1;
	logic [IW-1:0]    chk_idx_s1;
	logic [VW-1:0]    fit1_q;
	logic [IW-1:0]    res_idx_q;
	logic             res_flag_q;
	logic             out_vld_q;
	logic [IW-1:0]    out_idx_q;
	logic             out_flag_q;

	// input word fields
	logic [IW-1:0]    in_index;
	logic [VW-1:0]    in_fitness;
	logic [VW-1:0]    in_cumul;
	logic [VW-1:0]    in_draw_a;
	logic [VW-1:0]    in_draw_b;
	logic             accept;
	logic [SW-1:0]    n_eff;
	logic [SW-1:0]    last_idx;
	logic [PW-1:0]    prod_a;
	logic [PW-1:0]    prod_b;
	logic             out_free;

	assign in_index   = s_axis_tdata[5:0];
	assign in_fitness = s_axis_tdata[37:6];
	assign in_cumul   = s_axis_tdata[69:38];
	assign in_draw_a  = s_axis_tdata[101:70];
	assign in_draw_b  = s_axis_tdata[133:102];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign out_free      = !out_vld_q || m_axis_tready;

	// clamped size and tournament index scaling
	assign n_eff    = gps_pkg::eff_size(cfg.size);
	assign last_idx = n_q - SW'(1);
	assign prod_a   = PW'(in_draw_a) * PW'(n_eff);
	assign prod_b   = PW'(in_draw_b) * PW'(n_eff);

	// load words go straight into the table
	assign wr_en   = accept && (s_axis_tuser == gps_pkg::CMD_LOAD)
		&& ({1'b0, in_index} < (IW + 1)'(gps_pkg::MAX_POP));
	assign wr_addr = in_index;
	assign wr_data = '{fitness: in_fitness, cumulative: in_cumul};

	// table read address per state
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_addr_q;
		case (state_q)
			ST_SCAN: rd_en = !issue_done_q;
			ST_TRD1: begin
				rd_en   = 1'b1;
				rd_addr = i1_q;
			end
			ST_TRD2: begin
				rd_en   = 1'b1;
				rd_addr = i2_q;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_done_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			scan_addr_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && s_axis_tuser == gps_pkg::CMD_DRAW) begin
						scan_addr_q  <= '0;
						issue_done_q <= 1'b0;
						chk_vld_s1   <= 1'b0;
						state_q      <= (cfg.mode == gps_pkg::MODE_TOURNAMENT)
							? ST_TRD1 : ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_vld_s1 <= !issue_done_q;
					if (!issue_done_q) begin
						if ({1'b0, scan_addr_q} == last_idx) begin
							issue_done_q <= 1'b1;
						end else begin
							scan_addr_q <= scan_addr_q + IW'(1);
						end
					end
					if (chk_vld_s1 && ((rd_data.cumulative > draw_q)
						|| ({1'b0, chk_idx_s1} == last_idx))) begin
						state_q <= ST_DONE;
					end
				end
				ST_TRD1: state_q <= ST_TRD2;
				ST_TRD2: state_q <= ST_TCMP;
				ST_TCMP: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-draw payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= cfg.mode;
			n_q    <= n_eff;
			draw_q <= in_draw_a;
			i1_q   <= prod_a[VW +: IW];
			i2_q   <= prod_b[VW +: IW];
		end
		chk_idx_s1 <= scan_addr_q;
		// scan hit or fall-through
		if (state_q == ST_SCAN && chk_vld_s1) begin
			if (rd_data.cumulative > draw_q) begin
				res_idx_q  <= chk_idx_s1;
				res_flag_q <= 1'b0;
			end else begin
				res_idx_q  <= last_idx[IW-1:0];
				res_flag_q <= 1'b1;
			end
		end
		if (state_q == ST_TRD2) begin
			fit1_q <= rd_data.fitness;
		end
		// tie goes to the second pick
		if (state_q == ST_TCMP) begin
			res_idx_q  <= ($signed(fit1_q) > $signed(rd_data.fitness)) ? i1_q : i2_q;
			res_flag_q <= 1'b0;
		end
		if (state_q == ST_DONE && out_free) begin
			out_idx_q  <= res_idx_q;
			out_flag_q <= res_flag_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {1'b0, out_flag_q, out_idx_q};

	// result index stays inside the population in use
	a_res_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> ({1'b0, res_idx_q} < n_q))
		else $error("selected index outside population");

	// fall-through flag only with the last entry of a roulette draw
	a_flag_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_flag_q) |->
		({1'b0, res_idx_q} == last_idx && mode_q == gps_pkg::MODE_ROULETTE))
		else $error("fall-through flag without last entry");

	// tournament winner is one of the two picks
	a_tour_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && mode_q == gps_pkg::MODE_TOURNAMENT) |->
		(res_idx_q == i1_q || res_idx_q == i2_q))
		else $error("tournament winner not among picks");

	// scan never checks beyond the population in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && chk_vld_s1) |-> ({1'b0, chk_idx_s1} < n_q))
		else $error("scan past last entry");

	// no table write while a draw is in progress
	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_IDLE && !rd_en))
		else $error("table write during draw");

endmodule
